// ===== src/qt_pkg.sv =====
// Query tree reader package: widths, codes, FSM states and the structs
// passed between the controller, the stack RAM and the top level. No dependencies.
package qt_pkg;

  localparam int MAX_ID_BITS = 32;
  localparam int STACK_DEPTH = 64;

  localparam int PFX_W   = 32;
  localparam int LEN_W   = 6;
  localparam int CNT_W   = 16;
  localparam int INIT_W  = 3;
  localparam int ENT_W   = LEN_W + PFX_W;
  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int SP_W    = $clog2(STACK_DEPTH + 1);
  localparam int PRE_W   = (1 << INIT_W);
  localparam int PV_W    = PRE_W - 1;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_INIT_LEN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_ID_LEN   = 1'b1;

  localparam logic ACT_START  = 1'b0;
  localparam logic ACT_REPORT = 1'b1;

  localparam logic [1:0] CLS_IDLE  = 2'd0;
  localparam logic [1:0] CLS_IDENT = 2'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PRELOAD,
    ST_POP,
    ST_EMIT
  } qt_state_t;

  typedef struct packed {
    logic [INIT_W-1:0] init_len;
    logic [LEN_W-1:0]  id_len;
  } cfg_t;

  typedef struct packed {
    logic [PFX_W-1:0] query_prefix;
    logic [LEN_W-1:0] query_length;
    logic             done_res;
    logic             error_flag;
    logic [CNT_W-1:0] identified_count;
    logic [CNT_W-1:0] idle_count;
    logic [CNT_W-1:0] collision_count;
    logic [CNT_W-1:0] slot_count;
    logic [CNT_W-1:0] query_count;
  } res_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [ENT_W-1:0]  wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } stk_req_t;

endpackage

// ===== src/qt_if.sv =====
// Valid/ready channel interfaces for the query tree reader.
// Depends on qt_pkg for field widths.
interface qt_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [1:0] response_class;

  modport source (output valid, action, response_class, input ready);
  modport sink   (input valid, action, response_class, output ready);
endinterface

interface qt_out_if import qt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PFX_W-1:0] query_prefix;
  logic [LEN_W-1:0] query_length;
  logic             done_res;
  logic             error_flag;
  logic [CNT_W-1:0] identified_count;
  logic [CNT_W-1:0] idle_count;
  logic [CNT_W-1:0] collision_count;
  logic [CNT_W-1:0] slot_count;
  logic [CNT_W-1:0] query_count;

  modport source (output valid, query_prefix, query_length, done_res, error_flag,
                  identified_count, idle_count, collision_count, slot_count,
                  query_count, input ready);
  modport sink   (input valid, query_prefix, query_length, done_res, error_flag,
                  identified_count, idle_count, collision_count, slot_count,
                  query_count, output ready);
endinterface

// ===== src/qt_stack_ram.sv =====
// Simple dual-port RAM, one write and one registered read port.
// Holds the prefix stack entries; no dependencies.
module qt_stack_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 38
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/qt_ctrl.sv =====
// Query tree sequencer: round state, counters, stack pointer and RAM access.
// Depends on qt_pkg; drives qt_stack_ram through a stk_req_t.
module qt_ctrl import qt_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_action,
  input  logic [1:0]       in_class,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output stk_req_t         stk_req,
  input  logic [ENT_W-1:0] stk_rdata
);

  function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] a,
                                                 input logic [1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {{(CNT_W-1){1'b0}}, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

  qt_state_t        state_r, state_nxt;
  logic [SP_W-1:0]  sp_r, sp_nxt;
  logic [PFX_W-1:0] pfx_r, pfx_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [CNT_W-1:0] ident_r, ident_nxt;
  logic [CNT_W-1:0] idle_r, idle_nxt;
  logic [CNT_W-1:0] coll_r, coll_nxt;
  logic [CNT_W-1:0] push_r, push_nxt;
  logic [CNT_W-1:0] query_r, query_nxt;
  logic             rdone_r, rdone_nxt;
  logic             odone_r, odone_nxt;
  logic             oerr_r, oerr_nxt;
  logic [PV_W-1:0]  pv_r, pv_nxt;

  logic [LEN_W-1:0]  idl;
  logic [INIT_W-1:0] start_len;
  logic [PRE_W-1:0]  pre_cnt;
  logic [PRE_W-1:0]  pre_top;
  logic [SP_W-1:0]   sp_dec;

  always_comb begin
    if (cfg.id_len == '0) begin
      idl = LEN_W'(1);
    end else if (int'(cfg.id_len) > MAX_ID_BITS) begin
      idl = LEN_W'(MAX_ID_BITS);
    end else begin
      idl = cfg.id_len;
    end
  end

  assign start_len = ({{(LEN_W-INIT_W){1'b0}}, cfg.init_len} > idl) ? idl[INIT_W-1:0]
                                                                      : cfg.init_len;
  assign pre_cnt   = PRE_W'(1) << start_len;
  assign pre_top   = pre_cnt - PRE_W'(1);
  assign sp_dec    = sp_r - SP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r    <= '0;
      pfx_r   <= '0;
      len_r   <= '0;
      ident_r <= '0;
      idle_r  <= '0;
      coll_r  <= '0;
      push_r  <= '0;
      query_r <= '0;
      rdone_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      sp_r    <= sp_nxt;
      pfx_r   <= pfx_nxt;
      len_r   <= len_nxt;
      ident_r <= ident_nxt;
      idle_r  <= idle_nxt;
      coll_r  <= coll_nxt;
      push_r  <= push_nxt;
      query_r <= query_nxt;
      rdone_r <= rdone_nxt;
    end
  end

  always_ff @(posedge clk) begin
    odone_r <= odone_nxt;
    oerr_r  <= oerr_nxt;
    pv_r    <= pv_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    sp_nxt    = sp_r;
    pfx_nxt   = pfx_r;
    len_nxt   = len_r;
    ident_nxt = ident_r;
    idle_nxt  = idle_r;
    coll_nxt  = coll_r;
    push_nxt  = push_r;
    query_nxt = query_r;
    rdone_nxt = rdone_r;
    odone_nxt = odone_r;
    oerr_nxt  = oerr_r;
    pv_nxt    = pv_r;
    stk_req   = '0;
    in_ready  = (state_r == ST_IDLE);
    res_valid = (state_r == ST_EMIT);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          odone_nxt = 1'b0;
          oerr_nxt  = 1'b0;
          state_nxt = ST_EMIT;
          if (in_action == ACT_START) begin
            ident_nxt = '0;
            idle_nxt  = '0;
            coll_nxt  = '0;
            push_nxt  = '0;
            query_nxt = '0;
            sp_nxt    = '0;
            rdone_nxt = 1'b0;
            pfx_nxt   = '0;
            len_nxt   = '0;
            if (start_len >= INIT_W'(2)) begin
              if (int'(pre_top) > STACK_DEPTH) begin
                rdone_nxt = 1'b1;
                odone_nxt = 1'b1;
                oerr_nxt  = 1'b1;
              end else begin
                pv_nxt    = pre_top[PV_W-1:0];
                len_nxt   = LEN_W'(start_len);
                push_nxt  = CNT_W'(pre_cnt);
                state_nxt = ST_PRELOAD;
              end
            end else begin
              query_nxt = CNT_W'(1);
            end
          end else if (rdone_r) begin
            odone_nxt = 1'b1;
          end else begin
            if (in_class == CLS_IDENT) begin
              ident_nxt = cnt_add(ident_r, 2'd1);
            end else if (in_class == CLS_IDLE) begin
              idle_nxt = cnt_add(idle_r, 2'd1);
            end else begin
              coll_nxt = cnt_add(coll_r, 2'd1);
            end

            if (in_class != CLS_IDLE && in_class != CLS_IDENT) begin
              if (len_r >= idl || int'(sp_r) >= STACK_DEPTH) begin
                rdone_nxt = 1'b1;
                pfx_nxt   = '0;
                len_nxt   = '0;
                odone_nxt = 1'b1;
                oerr_nxt  = 1'b1;
              end else begin
                stk_req.we    = 1'b1;
                stk_req.waddr = sp_r[ADDR_W-1:0];
                stk_req.wdata = {len_r + LEN_W'(1), pfx_r[PFX_W-2:0], 1'b1};
                sp_nxt        = sp_r + SP_W'(1);
                push_nxt      = cnt_add(push_r, 2'd2);
                pfx_nxt       = {pfx_r[PFX_W-2:0], 1'b0};
                len_nxt       = len_r + LEN_W'(1);
                query_nxt     = cnt_add(query_r, 2'd1);
              end
            end else if (sp_r == '0) begin
              rdone_nxt = 1'b1;
              pfx_nxt   = '0;
              len_nxt   = '0;
              odone_nxt = 1'b1;
            end else begin
              stk_req.re    = 1'b1;
              stk_req.raddr = sp_dec[ADDR_W-1:0];
              sp_nxt        = sp_dec;
              query_nxt     = cnt_add(query_r, 2'd1);
              state_nxt     = ST_POP;
            end
          end
        end
      end

      ST_PRELOAD: begin
        stk_req.we    = 1'b1;
        stk_req.waddr = sp_r[ADDR_W-1:0];
        stk_req.wdata = {len_r, {(PFX_W-PV_W){1'b0}}, pv_r};
        sp_nxt        = sp_r + SP_W'(1);
        pv_nxt        = pv_r - PV_W'(1);
        if (pv_r == PV_W'(1)) begin
          query_nxt = CNT_W'(1);
          state_nxt = ST_EMIT;
        end
      end

      ST_POP: begin
        pfx_nxt   = stk_rdata[PFX_W-1:0];
        len_nxt   = stk_rdata[ENT_W-1:PFX_W];
        state_nxt = ST_EMIT;
      end

      ST_EMIT: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    res.query_prefix     = odone_r ? '0 : pfx_r;
    res.query_length     = odone_r ? '0 : len_r;
    res.done_res         = odone_r;
    res.error_flag       = oerr_r;
    res.identified_count = ident_r;
    res.idle_count       = idle_r;
    res.collision_count  = coll_r;
    res.slot_count       = cnt_add(push_r, 2'd1);
    res.query_count      = query_r;
  end

endmodule

// ===== src/query_tree_anticollision_reader_top.sv =====
// Query tree anti-collision reader, top level: config registers, output register.
// Depends on qt_pkg, qt_if, qt_stack_ram and qt_ctrl.
//
//  channel | direction | handshake          | words
//  in_ch   | sink      | valid/ready        | action, response_class
//  out_ch  | source    | valid/ready        | query prefix, length, flags, counts
//  cfg_*   | write     | cfg_we             | cfg_index, cfg_wdata
//
// A report goes idle to emit, or via the pop state to read the stack RAM.
// A start with preload length L writes 2^L - 1 entries, one stack RAM write each.
// The output register lets the next word in while the last result waits.
// rst_n clears the control state; stack entries need no clearing.
module query_tree_anticollision_reader_top import qt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  qt_in_if.sink                in_ch,
  qt_out_if.source             out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_wdata
);

  cfg_t             cfg_r;
  logic             res_valid;
  logic             res_ready;
  res_t             res;
  stk_req_t         stk_req;
  logic [ENT_W-1:0] stk_rdata;
  logic             out_valid_r;
  res_t             out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.init_len <= '0;
      cfg_r.id_len   <= LEN_W'(32);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INIT_LEN: cfg_r.init_len <= cfg_wdata[INIT_W-1:0];
        CFG_ID_LEN:   cfg_r.id_len   <= cfg_wdata;
      endcase
    end
  end

  qt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .in_class  (in_ch.response_class),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .stk_req   (stk_req),
    .stk_rdata (stk_rdata)
  );

  qt_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (ENT_W)
  ) u_stack_ram (
    .clk   (clk),
    .we    (stk_req.we),
    .waddr (stk_req.waddr),
    .wdata (stk_req.wdata),
    .re    (stk_req.re),
    .raddr (stk_req.raddr),
    .rdata (stk_rdata)
  );

  assign res_ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.query_prefix     = out_data_r.query_prefix;
  assign out_ch.query_length     = out_data_r.query_length;
  assign out_ch.done_res         = out_data_r.done_res;
  assign out_ch.error_flag       = out_data_r.error_flag;
  assign out_ch.identified_count = out_data_r.identified_count;
  assign out_ch.idle_count       = out_data_r.idle_count;
  assign out_ch.collision_count  = out_data_r.collision_count;
  assign out_ch.slot_count       = out_data_r.slot_count;
  assign out_ch.query_count      = out_data_r.query_count;

endmodule

// ===== bench/query_tree_anticollision_reader_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the query tree anti-collision reader top level.
// Depends on qt_pkg, the qt_in_if/qt_out_if channel interfaces and the reader RTL.
module query_tree_anticollision_reader_top_test;
  import qt_pkg::*;

  localparam logic [1:0] CLS_SPLIT = 2'd2;
  localparam logic [1:0] CLS_ODD   = 2'd3;
  localparam int GEN = 0;
  localparam int CHK = 1;
  localparam int CNT_MAX = (1 << CNT_W) - 1;
  localparam int CYCLE_LIMIT = 4_000_000;

  typedef struct packed {
    logic       action;
    logic [1:0] cls;
  } word_t;

  typedef struct packed {
    logic [STACK_DEPTH-1:0][PFX_W-1:0] stack_pfx;
    logic [STACK_DEPTH-1:0][LEN_W-1:0] stack_len;
    logic [SP_W-1:0]                   sp;
    logic [PFX_W-1:0]                  cur_pfx;
    logic [LEN_W-1:0]                  cur_len;
    logic [CNT_W-1:0]                  ident;
    logic [CNT_W-1:0]                  idle;
    logic [CNT_W-1:0]                  coll;
    logic [CNT_W-1:0]                  pushes;
    logic [CNT_W-1:0]                  queries;
    logic                              finished;
  } tree_state_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_action = 1'b0;
  logic [1:0] in_class = 2'd0;
  logic out_ready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [LEN_W-1:0] cfg_wdata = '0;
  logic steady = 1'b0;

  logic [INIT_W-1:0] init_cfg = '0;
  logic [LEN_W-1:0] id_cfg = LEN_W'(32);
  tree_state_t reader [2];
  word_t pending_words [$];
  res_t due_queries [$];
  word_t next_word;
  res_t seen, want;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  qt_in_if in_ch ();
  qt_out_if out_ch ();

  assign in_ch.valid = in_valid;
  assign in_ch.action = in_action;
  assign in_ch.response_class = in_class;
  assign out_ch.ready = out_ready;

  query_tree_anticollision_reader_top DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] a, int b);
    int s;
    s = int'(a) + b;
    return (s > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(s);
  endfunction

  function automatic int eff_id_len();
    if (id_cfg == 0) return 1;
    if (id_cfg > MAX_ID_BITS) return MAX_ID_BITS;
    return int'(id_cfg);
  endfunction

  function automatic void push_prefix(int w, logic [PFX_W-1:0] p, int l);
    int sp;
    sp = int'(reader[w].sp);
    reader[w].stack_pfx[sp] = p;
    reader[w].stack_len[sp] = LEN_W'(l);
    reader[w].sp = SP_W'(sp + 1);
  endfunction

  function automatic res_t query_word(int w, logic done, logic err);
    res_t r;
    r.query_prefix = done ? '0 : reader[w].cur_pfx;
    r.query_length = done ? '0 : reader[w].cur_len;
    r.done_res = done;
    r.error_flag = err;
    r.identified_count = reader[w].ident;
    r.idle_count = reader[w].idle;
    r.collision_count = reader[w].coll;
    r.slot_count = sat_add(reader[w].pushes, 1);
    r.query_count = reader[w].queries;
    return r;
  endfunction

  function automatic res_t close_round(int w, logic err);
    reader[w].finished = 1'b1;
    reader[w].cur_pfx = '0;
    reader[w].cur_len = '0;
    return query_word(w, 1'b1, err);
  endfunction

  function automatic res_t reader_step(int w, logic act, logic [1:0] cls);
    int idl;
    int plen;
    int sp;
    idl = eff_id_len();
    if (act == ACT_START) begin
      plen = int'(init_cfg);
      reader[w].ident = '0;
      reader[w].idle = '0;
      reader[w].coll = '0;
      reader[w].pushes = '0;
      reader[w].queries = '0;
      reader[w].sp = '0;
      reader[w].finished = 1'b0;
      reader[w].cur_pfx = '0;
      reader[w].cur_len = '0;
      if (plen > idl) plen = idl;
      if (plen >= 2) begin
        if ((1 << plen) - 1 > STACK_DEPTH) return close_round(w, 1'b1);
        for (int v = (1 << plen) - 1; v >= 1; v--) push_prefix(w, PFX_W'(v), plen);
        reader[w].pushes = sat_add('0, 1 << plen);
        reader[w].cur_len = LEN_W'(plen);
      end
      reader[w].queries = CNT_W'(1);
      return query_word(w, 1'b0, 1'b0);
    end
    if (reader[w].finished) return query_word(w, 1'b1, 1'b0);
    case (cls)
      CLS_IDENT: reader[w].ident = sat_add(reader[w].ident, 1);
      CLS_IDLE:  reader[w].idle = sat_add(reader[w].idle, 1);
      default:   reader[w].coll = sat_add(reader[w].coll, 1);
    endcase
    if (cls == CLS_SPLIT || cls == CLS_ODD) begin
      if (int'(reader[w].cur_len) >= idl || int'(reader[w].sp) >= STACK_DEPTH)
        return close_round(w, 1'b1);
      push_prefix(w, {reader[w].cur_pfx[PFX_W-2:0], 1'b1}, int'(reader[w].cur_len) + 1);
      reader[w].pushes = sat_add(reader[w].pushes, 2);
      reader[w].cur_pfx = {reader[w].cur_pfx[PFX_W-2:0], 1'b0};
      reader[w].cur_len = reader[w].cur_len + LEN_W'(1);
    end else begin
      if (reader[w].sp == 0) return close_round(w, 1'b0);
      sp = int'(reader[w].sp) - 1;
      reader[w].sp = SP_W'(sp);
      reader[w].cur_pfx = reader[w].stack_pfx[sp];
      reader[w].cur_len = reader[w].stack_len[sp];
    end
    reader[w].queries = sat_add(reader[w].queries, 1);
    return query_word(w, 1'b0, 1'b0);
  endfunction

  function automatic void queue_word(logic act, logic [1:0] cls);
    word_t wd;
    wd.action = act;
    wd.cls = cls;
    pending_words.insert(pending_words.size(), wd);
    void'(reader_step(GEN, act, cls));
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%0t: %s", $time, msg);
  endtask

  task automatic check_field(string field, logic [PFX_W-1:0] got, logic [PFX_W-1:0] exp_val);
    if (got !== exp_val)
      report_mismatch($sformatf("%s got %0h expected %0h", field, got, exp_val));
  endtask

  task automatic wait_drained();
    while (pending_words.size() != 0 || in_valid || due_queries.size() != 0)
      @(negedge clk);
  endtask

  task automatic set_config(logic [INIT_W-1:0] init_len, logic [LEN_W-1:0] id_len);
    logic [LEN_W-INIT_W-1:0] pad;
    pad = (LEN_W-INIT_W)'($urandom);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INIT_LEN;
    cfg_wdata <= {pad, init_len};
    @(posedge clk);
    cfg_index <= CFG_ID_LEN;
    cfg_wdata <= id_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    init_cfg = init_len;
    id_cfg = id_len;
    @(negedge clk);
  endtask

  task automatic queue_random(int n);
    int pick;
    logic act;
    logic [1:0] cls;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      cls = 2'($urandom_range(3));
      if (reader[GEN].finished) begin
        act = (pick < 88) ? ACT_START : ACT_REPORT;
      end else if (pick < 3) begin
        act = ACT_START;
      end else begin
        act = ACT_REPORT;
        pick = $urandom_range(99);
        if (int'(reader[GEN].cur_len) >= eff_id_len() && pick < 85)
          cls = (pick % 2 == 0) ? CLS_IDENT : CLS_IDLE;
        else if (pick < 5) cls = CLS_ODD;
        else if (pick < 45) cls = CLS_SPLIT;
        else if (pick < 72) cls = CLS_IDENT;
        else cls = CLS_IDLE;
      end
      queue_word(act, cls);
    end
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("query_tree_anticollision_reader_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ch.ready)
        due_queries.insert(due_queries.size(), reader_step(CHK, in_action, in_class));
      if (!in_valid || in_ch.ready) begin
        if (pending_words.size() != 0 && (steady || $urandom_range(99) >= 34)) begin
          next_word = pending_words.pop_front();
          in_valid <= 1'b1;
          in_action <= next_word.action;
          in_class <= next_word.cls;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ready) begin
        seen.query_prefix = out_ch.query_prefix;
        seen.query_length = out_ch.query_length;
        seen.done_res = out_ch.done_res;
        seen.error_flag = out_ch.error_flag;
        seen.identified_count = out_ch.identified_count;
        seen.idle_count = out_ch.idle_count;
        seen.collision_count = out_ch.collision_count;
        seen.slot_count = out_ch.slot_count;
        seen.query_count = out_ch.query_count;
        if (due_queries.size() == 0) begin
          report_mismatch("query word with nothing outstanding");
        end else begin
          want = due_queries.pop_front();
          check_field("query_prefix", seen.query_prefix, want.query_prefix);
          check_field("query_length", PFX_W'(seen.query_length), PFX_W'(want.query_length));
          check_field("done_res", PFX_W'(seen.done_res), PFX_W'(want.done_res));
          check_field("error_flag", PFX_W'(seen.error_flag), PFX_W'(want.error_flag));
          check_field("identified_count", PFX_W'(seen.identified_count),
                      PFX_W'(want.identified_count));
          check_field("idle_count", PFX_W'(seen.idle_count), PFX_W'(want.idle_count));
          check_field("collision_count", PFX_W'(seen.collision_count),
                      PFX_W'(want.collision_count));
          check_field("slot_count", PFX_W'(seen.slot_count), PFX_W'(want.slot_count));
          check_field("query_count", PFX_W'(seen.query_count), PFX_W'(want.query_count));
        end
      end
      out_ready <= steady || ($urandom_range(99) >= 34);
    end
  end

  initial begin
    logic [INIT_W-1:0] init_pick;
    logic [LEN_W-1:0] id_pick;
    for (int w = 0; w < 2; w++) begin
      reader[w] = '0;
      reader[w].finished = 1'b1;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_word(ACT_REPORT, CLS_IDLE);
    queue_word(ACT_REPORT, CLS_ODD);
    queue_word(ACT_START, CLS_ODD);
    queue_word(ACT_REPORT, CLS_SPLIT);
    queue_word(ACT_REPORT, CLS_ODD);
    queue_word(ACT_REPORT, CLS_IDENT);
    queue_word(ACT_REPORT, CLS_IDLE);
    queue_word(ACT_REPORT, CLS_IDENT);
    queue_word(ACT_REPORT, CLS_IDLE);
    wait_drained();
    set_config(3'd7, 6'd63);
    queue_word(ACT_START, CLS_IDENT);
    queue_word(ACT_REPORT, CLS_IDENT);
    wait_drained();
    set_config(3'd6, 6'd8);
    queue_word(ACT_START, CLS_IDLE);
    queue_word(ACT_REPORT, CLS_SPLIT);
    queue_word(ACT_REPORT, CLS_SPLIT);
    wait_drained();
    set_config(3'd3, 6'd1);
    queue_word(ACT_START, CLS_SPLIT);
    queue_word(ACT_REPORT, CLS_SPLIT);
    queue_word(ACT_REPORT, CLS_SPLIT);
    wait_drained();
    set_config(3'd2, 6'd0);
    queue_word(ACT_START, CLS_IDLE);
    queue_word(ACT_REPORT, CLS_IDLE);
    queue_word(ACT_START, CLS_ODD);
    queue_word(ACT_REPORT, CLS_SPLIT);
    queue_word(ACT_REPORT, CLS_SPLIT);
    wait_drained();
    set_config(3'd4, 6'd32);
    queue_word(ACT_START, CLS_IDLE);
    queue_word(ACT_REPORT, CLS_ODD);
    queue_word(ACT_REPORT, CLS_IDLE);

    for (int s = 0; s < 12; s++) begin
      wait_drained();
      init_pick = INIT_W'($urandom_range(7));
      case ($urandom_range(3))
        0:       id_pick = LEN_W'($urandom_range(6, 1));
        3:       id_pick = $urandom_range(1) ? 6'd0 : 6'($urandom_range(63, 33));
        default: id_pick = LEN_W'($urandom_range(32, 7));
      endcase
      set_config(init_pick, id_pick);
      steady <= (s == 5);
      queue_random(75);
      wait_drained();
      queue_random(75);
    end

    wait_drained();
    queue_random(16);

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("query_tree_anticollision_reader_top: match");
    else
      $display("query_tree_anticollision_reader_top: mismatch");
    $finish;
  end

endmodule

// ===== files.f =====
src/qt_pkg.sv
src/qt_if.sv
src/qt_stack_ram.sv
src/qt_ctrl.sv
src/query_tree_anticollision_reader_top.sv
bench/query_tree_anticollision_reader_top_test.sv
